// File: rtl/pfla_pkg.sv
`timescale 1ns / 1ps

package pfla_pkg;

    // Fixed field widths
    localparam int ADDR_W    = 40;
    localparam int MODE_W    = 2;
    localparam int REQ_W     = 8;
    localparam int STAT_W    = 3;
    localparam int FCNT_W    = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [STAT_W-1:0] t_status;

    // Operation codes
    localparam t_mode MODE_INIT  = 2'd0;
    localparam t_mode MODE_ALLOC = 2'd1;
    localparam t_mode MODE_FREE  = 2'd2;

    // Status codes
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_BAD   = 3'd2;
    localparam t_status ST_UNSUP = 3'd3;
    localparam t_status ST_NULL  = 3'd4;
    localparam t_status ST_OVER  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP     = 1'd1;

    // Configuration reset values
    localparam t_addr REGION_START_RST = 40'h00_8000_0000;
    localparam t_addr PHYS_TOP_RST     = 40'h00_8800_0000;

endpackage

// File: rtl/pfla_in_if.sv
`timescale 1ns / 1ps

interface pfla_in_if import pfla_pkg::*; ();
    logic             valid;
    logic             ready;
    t_mode            mode;
    t_addr            page_addr;
    logic [REQ_W-1:0] request_pages;

    modport source (output valid, output mode, output page_addr, output request_pages,
                    input ready);
    modport sink   (input valid, input mode, input page_addr, input request_pages,
                    output ready);
endinterface

// File: rtl/pfla_out_if.sv
`timescale 1ns / 1ps

interface pfla_out_if import pfla_pkg::*; ();
    logic              valid;
    logic              ready;
    t_addr             alloc_addr;
    t_status           status;
    logic [FCNT_W-1:0] free_count;

    modport source (output valid, output alloc_addr, output status, output free_count,
                    input ready);
    modport sink   (input valid, input alloc_addr, input status, input free_count,
                    output ready);
endinterface

// File: rtl/page_free_list_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake       Payload
// i_in      in         valid / ready   mode, page_addr, request_pages
// o_out     out        valid / ready   alloc_addr, status, free_count
// i_cfg_*   in         write enable    register index, 40-bit data
//
// Alloc and free do the stack access as the item is accepted (registered
// read for alloc, write for free), then hand the item to the output
// register. Init first pushes the pages of the range (one stack write per cycle).
// Reset clears the stack depth only; the stack memory is not cleared. A
// stalled output holds the finished item; the next item is accepted once
// the previous result sits in the output register.
// PAGE_SIZE must be a power of two.

module page_free_list_allocator
    import pfla_pkg::*;
#(
    parameter int PAGE_SIZE = 4096,
    parameter int MAX_PAGES = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_addr                i_cfg_data,
    pfla_in_if.sink              i_in,
    pfla_out_if.source           o_out
);

    localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    localparam int NP_W       = PN_W + 1;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    localparam logic [ADDR_W:0] FIRST_RST_A =
        {1'b0, REGION_START_RST} + (ADDR_W+1)'(PAGE_SIZE - 1);
    localparam logic [NP_W-1:0] FIRST_PN_RST = FIRST_RST_A[ADDR_W:PAGE_SHIFT];
    localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_PAGES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INIT = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    // Stack memory
    logic [PN_W-1:0] mem [MAX_PAGES];

    logic [1:0]       r_state,     n_state;
    logic [CNT_W-1:0] r_depth,     n_depth;
    logic [CNT_W-1:0] r_init_cnt,  n_init_cnt;
    logic [NP_W-1:0]  r_first_pn,  n_first_pn;
    t_addr            r_top,       n_top;
    t_status          r_res_st,    n_res_st;
    logic             r_res_alloc, n_res_alloc;
    logic [PN_W-1:0]  r_rd_data;
    logic             r_out_valid, n_out_valid;
    t_addr            r_out_addr,  n_out_addr;
    t_status          r_out_st,    n_out_st;
    logic [FCNT_W-1:0] r_out_cnt,  n_out_cnt;

    logic             acc;
    logic [PN_W-1:0]  pa_pn;
    logic             free_bad;
    logic             full;
    logic [PN_W-1:0]  pend_pn;
    logic [NP_W-1:0]  span;
    logic             has_pages;
    logic             over;
    logic [CNT_W-1:0] npages;
    logic [ADDR_W:0]  cfg_round;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [PN_W-1:0]  wr_data;
    logic             out_load;

    assign i_in.ready       = (r_state == S_IDLE);
    assign acc              = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.alloc_addr = r_out_addr;
    assign o_out.status     = r_out_st;
    assign o_out.free_count = r_out_cnt;

    // Decode free checks and the init range
    always_comb begin
        pa_pn     = i_in.page_addr[ADDR_W-1:PAGE_SHIFT];
        free_bad  = (|i_in.page_addr[PAGE_SHIFT-1:0]) || ({1'b0, pa_pn} < r_first_pn)
                    || (i_in.page_addr >= r_top);
        full      = (r_depth >= MAX_CNT);
        pend_pn   = r_top[ADDR_W-1:PAGE_SHIFT];
        span      = {1'b0, pend_pn} - r_first_pn;
        has_pages = ({1'b0, pend_pn} > r_first_pn);
        over      = has_pages && (span > NP_W'(MAX_PAGES));
        if (!has_pages) begin
            npages = '0;
        end else if (over) begin
            npages = MAX_CNT;
        end else begin
            npages = CNT_W'(span);
        end
        cfg_round = {1'b0, i_cfg_data} + (ADDR_W+1)'(PAGE_SIZE - 1);
    end

    // Sequence the operation
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_init_cnt  = r_init_cnt;
        n_first_pn  = r_first_pn;
        n_top       = r_top;
        n_res_st    = r_res_st;
        n_res_alloc = r_res_alloc;
        rd_en       = 1'b0;
        rd_idx      = r_depth[IDX_W-1:0] - IDX_W'(1);
        wr_en       = 1'b0;
        wr_data     = pa_pn;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGION_START: n_first_pn = cfg_round[ADDR_W:PAGE_SHIFT];
                CFG_PHYS_TOP:     n_top      = i_cfg_data;
                default:          ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_res_st    = ST_OK;
                    n_res_alloc = 1'b0;
                    n_state     = S_WAIT;
                    case (i_in.mode)
                        MODE_INIT: begin
                            n_depth    = '0;
                            n_init_cnt = npages;
                            n_res_st   = over ? ST_OVER : ST_OK;
                            if (has_pages) begin
                                n_state = S_INIT;
                            end
                        end
                        MODE_ALLOC: begin
                            if (i_in.request_pages > REQ_W'(1)) begin
                                n_res_st = ST_UNSUP;
                            end else if (r_depth == '0) begin
                                n_res_st = ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                n_depth     = r_depth - CNT_W'(1);
                                n_res_alloc = 1'b1;
                            end
                        end
                        MODE_FREE: begin
                            if (i_in.page_addr == '0) begin
                                n_res_st = ST_NULL;
                            end else if (free_bad) begin
                                n_res_st = ST_BAD;
                            end else if (full) begin
                                n_res_st = ST_OVER;
                            end else begin
                                wr_en   = 1'b1;
                                n_depth = r_depth + CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                // Push base + depth, one page a cycle
                wr_en   = 1'b1;
                wr_data = r_first_pn[PN_W-1:0] + PN_W'(r_depth);
                n_depth = r_depth + CNT_W'(1);
                if (n_depth == r_init_cnt) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Fill the output register from the finished item
    always_comb begin
        out_load    = (r_state == S_WAIT) && (!r_out_valid || o_out.ready);
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_st    = r_out_st;
        n_out_cnt   = r_out_cnt;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_addr  = r_res_alloc ? {r_rd_data, {PAGE_SHIFT{1'b0}}} : '0;
            n_out_st    = r_res_st;
            n_out_cnt   = FCNT_W'(r_depth);
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_init_cnt  <= '0;
            r_first_pn  <= FIRST_PN_RST;
            r_top       <= PHYS_TOP_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_init_cnt  <= n_init_cnt;
            r_first_pn  <= n_first_pn;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res_st    <= n_res_st;
        r_res_alloc <= n_res_alloc;
        r_out_addr  <= n_out_addr;
        r_out_st    <= n_out_st;
        r_out_cnt   <= n_out_cnt;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_depth[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    // Depth stays within the stack
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= MAX_CNT)
        else $error("stack depth above capacity");

    // Init walk never writes past its target
    a_init_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (r_depth < r_init_cnt))
        else $error("init walk past target");

    // A successful alloc pops exactly one entry
    a_alloc_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.mode == MODE_ALLOC && i_in.request_pages <= REQ_W'(1)
         && r_depth != '0) |=> (r_depth == $past(r_depth) - CNT_W'(1)))
        else $error("alloc did not pop one entry");

    // Only a successful alloc returns an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != ST_OK) |-> (r_out_addr == '0))
        else $error("address given with failing status");

    // No item accepted while a result is still staged
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT || r_state == S_INIT) |-> !acc)
        else $error("item accepted while busy");

endmodule

// File: tb/page_free_list_allocator_test.sv
`timescale 1ns / 1ps

module page_free_list_allocator_test;
    import pfla_pkg::*;

    localparam int          PAGE_BYTES   = 4096;
    localparam int          STACK_PAGES  = 32768;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam t_mode       MODE_NOP     = 2'd3;
    localparam t_addr       ADDR_MAX     = 40'hFF_FFFF_FFFF;

    typedef enum {OP_ITEM, OP_CFG, OP_DRAIN, OP_PACE} t_op_kind;

    typedef struct {
        t_op_kind             kind;
        t_mode                mode;
        t_addr                page_addr;
        logic [REQ_W-1:0]     request_pages;
        logic [CFG_IDX_W-1:0] cfg_idx;
        t_addr                cfg_data;
        int                   idle_pct;
        int                   stall_pct;
    } t_alloc_op;

    typedef struct {
        t_mode             mode;
        t_addr             alloc_addr;
        t_status           status;
        logic [FCNT_W-1:0] free_count;
    } t_alloc_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_addr                cfg_data;

    pfla_in_if  in_ch ();
    pfla_out_if out_ch ();

    page_free_list_allocator #(
        .PAGE_SIZE (PAGE_BYTES),
        .MAX_PAGES (STACK_PAGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Free stack mirror and configuration as the block should hold them
    bit [27:0]   model_stack [STACK_PAGES];
    int unsigned model_depth  = 0;
    t_addr       model_region = REGION_START_RST;
    t_addr       model_top    = PHYS_TOP_RST;

    t_alloc_op     op_q[$];
    t_alloc_result pending_results[$];
    t_alloc_op     on_bus;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          mismatches     = 0;
    int          items_accepted = 0;
    int          cfg_writes     = 0;
    int          status_seen [8];
    int unsigned cycle_count    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one item to the mirror and return the result it should produce
    function automatic t_alloc_result predict_allocator_step(input t_alloc_op op);
        t_alloc_result   r;
        longint unsigned pstart, pend, npages, pa, top64, k;
        r.mode       = op.mode;
        r.alloc_addr = '0;
        r.status     = ST_OK;
        top64        = model_top;
        pa           = op.page_addr;
        pstart       = model_region;
        pstart       = ((pstart + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        case (op.mode)
            MODE_INIT: begin
                pend   = (top64 / PAGE_BYTES) * PAGE_BYTES;
                npages = (pend > pstart) ? (pend - pstart) / PAGE_BYTES : 0;
                if (npages > STACK_PAGES) begin
                    npages   = STACK_PAGES;
                    r.status = ST_OVER;
                end
                for (k = 0; k < npages; k++)
                    model_stack[k] = 28'((pstart / PAGE_BYTES) + k);
                model_depth = 32'(npages);
            end
            MODE_ALLOC: begin
                if (op.request_pages > 1) begin
                    r.status = ST_UNSUP;
                end else if (model_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    model_depth--;
                    pa           = model_stack[model_depth];
                    r.alloc_addr = ADDR_W'(pa * PAGE_BYTES);
                end
            end
            MODE_FREE: begin
                if (pa == 0) begin
                    r.status = ST_NULL;
                end else if ((pa % PAGE_BYTES) != 0 || pa < pstart || pa >= top64) begin
                    r.status = ST_BAD;
                end else if (model_depth >= STACK_PAGES) begin
                    r.status = ST_OVER;
                end else begin
                    model_stack[model_depth] = 28'(pa / PAGE_BYTES);
                    model_depth++;
                end
            end
            default: ;
        endcase
        r.free_count = model_depth[FCNT_W-1:0];
        return r;
    endfunction

    task automatic add_item(input t_mode mode, input t_addr addr, input logic [REQ_W-1:0] req);
        t_alloc_op o;
        o.kind          = OP_ITEM;
        o.mode          = mode;
        o.page_addr     = addr;
        o.request_pages = req;
        op_q.push_back(o);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input t_addr data);
        t_alloc_op o;
        o.kind     = OP_CFG;
        o.cfg_idx  = idx;
        o.cfg_data = data;
        op_q.push_back(o);
    endtask

    task automatic add_pace(input int idle_pct, input int stall_pct);
        t_alloc_op o;
        o.kind      = OP_PACE;
        o.idle_pct  = idle_pct;
        o.stall_pct = stall_pct;
        op_q.push_back(o);
    endtask

    task automatic add_drain();
        t_alloc_op o;
        o.kind = OP_DRAIN;
        op_q.push_back(o);
    endtask

    // One small managed range, an init, then mostly legal allocs and frees
    task automatic add_random_phase(input int n_ops, input int pace_sel);
        longint unsigned base, pstart, top, good, outside;
        int              npg, span, pick, i;
        t_addr           junk;
        logic [REQ_W-1:0] req;
        if ($urandom_range(9) == 0)
            base = $urandom_range(16'h3000);
        else
            base = {8'($urandom_range(254)), 32'($urandom)};
        npg    = $urandom_range(48);
        pstart = ((base + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        if ($urandom_range(19) == 0)
            top = base / 2;
        else
            top = pstart + longint'(npg) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
        span = (top > pstart) ? int'((top - pstart + PAGE_BYTES - 1) / PAGE_BYTES) : 1;

        add_cfg(CFG_REGION_START, ADDR_W'(base));
        add_cfg(CFG_PHYS_TOP, ADDR_W'(top));
        case (pace_sel)
            0:       add_pace(0, 0);
            1:       add_pace(61, 0);
            2:       add_pace(0, 61);
            default: add_pace(25, 25);
        endcase
        add_item(MODE_INIT, {8'($urandom), 32'($urandom)}, 8'($urandom));

        for (i = 0; i < n_ops; i++) begin
            // hold off once per phase until the block has emptied
            if (i == n_ops / 2)
                add_drain();
            pick = $urandom_range(99);
            junk = {8'($urandom), 32'($urandom)};
            req  = 8'($urandom);
            good = pstart + longint'($urandom_range(span - 1)) * PAGE_BYTES;
            case ($urandom_range(2))
                0:       outside = (pstart > 4 * PAGE_BYTES) ?
                                   pstart - longint'($urandom_range(1, 4)) * PAGE_BYTES : junk;
                1:       outside = ((top + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES +
                                   longint'($urandom_range(3)) * PAGE_BYTES;
                default: outside = junk;
            endcase
            if (pick < 38)
                add_item(MODE_ALLOC, junk, 8'($urandom_range(1)));
            else if (pick < 76)
                add_item(MODE_FREE, ADDR_W'(good), req);
            else if (pick < 80)
                add_item(MODE_FREE, '0, req);
            else if (pick < 86)
                add_item(MODE_FREE, ADDR_W'(good + $urandom_range(1, PAGE_BYTES - 1)), req);
            else if (pick < 90)
                add_item(MODE_FREE, ADDR_W'(outside), req);
            else if (pick < 94)
                add_item(MODE_ALLOC, junk, 8'($urandom_range(2, 255)));
            else if (pick < 97)
                add_item(MODE_NOP, junk, req);
            else
                add_item(MODE_INIT, junk, req);
        end
    endtask

    // Driver: offer items, write registers while idle, honor pauses
    always @(posedge i_clk) begin : driver
        logic next_valid;
        logic next_we;
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.mode          <= MODE_INIT;
            in_ch.page_addr     <= '0;
            in_ch.request_pages <= '0;
            cfg_we              <= 1'b0;
            cfg_idx             <= CFG_REGION_START;
            cfg_data            <= '0;
        end else begin
            next_valid = in_ch.valid;
            next_we    = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                pending_results.push_back(predict_allocator_step(on_bus));
                items_accepted++;
                next_valid = 1'b0;
            end
            if (pending_results.size() == 0 && !next_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!next_valid && op_q.size() != 0) begin
                case (op_q[0].kind)
                    OP_ITEM: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            on_bus = op_q.pop_front();
                            in_ch.mode          <= on_bus.mode;
                            in_ch.page_addr     <= on_bus.page_addr;
                            in_ch.request_pages <= on_bus.request_pages;
                            next_valid = 1'b1;
                        end
                    end
                    OP_CFG: begin
                        if (quiet_cycles >= DRAIN_CYCLES) begin
                            cfg_idx  <= op_q[0].cfg_idx;
                            cfg_data <= op_q[0].cfg_data;
                            next_we = 1'b1;
                            if (op_q[0].cfg_idx == CFG_REGION_START)
                                model_region = op_q[0].cfg_data;
                            else
                                model_top = op_q[0].cfg_data;
                            cfg_writes++;
                            void'(op_q.pop_front());
                        end
                    end
                    OP_DRAIN: begin
                        if (pending_results.size() == 0)
                            void'(op_q.pop_front());
                    end
                    OP_PACE: begin
                        send_idle_pct  = op_q[0].idle_pct;
                        recv_stall_pct = op_q[0].stall_pct;
                        void'(op_q.pop_front());
                    end
                    default: ;
                endcase
            end
            in_ch.valid <= next_valid;
            cfg_we      <= next_we;
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_alloc_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                status_seen[out_ch.status]++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: alloc_addr %h status %0d free_count %0d",
                             $time, out_ch.alloc_addr, out_ch.status, out_ch.free_count);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.alloc_addr !== want.alloc_addr) begin
                        $display("%0t: mode %0d alloc_addr expected %h, actual %h",
                                 $time, want.mode, want.alloc_addr, out_ch.alloc_addr);
                        mismatches++;
                    end
                    if (out_ch.status !== want.status) begin
                        $display("%0t: mode %0d status expected %0d, actual %0d",
                                 $time, want.mode, want.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.free_count !== want.free_count) begin
                        $display("%0t: mode %0d free_count expected %0d, actual %0d",
                                 $time, want.mode, want.free_count, out_ch.free_count);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int produced;
        int phase_no;
        int n_ops;
        i_rst_n = 1'b0;

        // Directed: reset configuration, full stack, every status
        add_pace(0, 0);
        add_item(MODE_ALLOC, '0, 8'd1);                 // empty after reset
        add_item(MODE_FREE, '0, 8'd0);                  // null address ignored
        add_item(MODE_NOP, ADDR_MAX, 8'hFF);            // no operation
        add_item(MODE_INIT, '0, 8'd0);                  // exactly a full stack
        add_item(MODE_FREE, 40'h00_8000_0000, 8'd0);    // push into full stack
        add_item(MODE_ALLOC, '0, 8'hFF);                // multi-page request
        add_item(MODE_ALLOC, '0, 8'd1);
        add_item(MODE_ALLOC, ADDR_MAX, 8'd0);
        add_item(MODE_FREE, 40'h00_87FF_F000, 8'd0);
        add_item(MODE_FREE, 40'h00_87FF_F000, 8'd0);    // double free
        add_item(MODE_FREE, 40'h00_87FF_E000, 8'd0);    // full again
        add_item(MODE_FREE, 40'h00_8000_0001, 8'd0);    // misaligned
        add_item(MODE_FREE, 40'h00_7FFF_F000, 8'd0);    // below region
        add_item(MODE_FREE, 40'h00_8800_0000, 8'd0);    // at top
        add_item(MODE_FREE, ADDR_MAX, 8'd0);
        // whole address space: more pages than fit
        add_cfg(CFG_REGION_START, '0);
        add_cfg(CFG_PHYS_TOP, ADDR_MAX);
        add_item(MODE_INIT, '0, 8'd0);
        add_item(MODE_ALLOC, '0, 8'd1);
        // region start rounds up past the address space
        add_cfg(CFG_REGION_START, ADDR_MAX);
        add_item(MODE_INIT, '0, 8'd0);
        add_item(MODE_FREE, 40'hFF_FFFF_F000, 8'd0);
        add_item(MODE_ALLOC, '0, 8'd1);
        // unaligned bounds: free accepted in the partial top page
        add_cfg(CFG_REGION_START, 40'h1);
        add_cfg(CFG_PHYS_TOP, 40'h3FFF);
        add_item(MODE_INIT, '0, 8'd0);
        add_item(MODE_ALLOC, '0, 8'd0);
        add_item(MODE_FREE, 40'h3000, 8'd1);
        add_item(MODE_FREE, 40'h1000, 8'd1);
        // inverted range leaves the stack empty
        add_cfg(CFG_REGION_START, 40'h5000);
        add_cfg(CFG_PHYS_TOP, 40'h2000);
        add_item(MODE_INIT, '0, 8'd0);
        add_item(MODE_ALLOC, '0, 8'd1);

        // Random phases, cycling through the idle and stall levels
        produced = 0;
        phase_no = 0;
        while (produced < RANDOM_ITEMS) begin
            n_ops = $urandom_range(40, 80);
            add_random_phase(n_ops, phase_no % 4);
            produced += n_ops + 1;
            phase_no++;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_q.size() != 0 || in_ch.valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items over %0d phases with %0d register writes, %0d mismatches",
                 items_accepted, phase_no, cfg_writes, mismatches);
        $display("Results by status: ok %0d empty %0d bad %0d unsupported %0d null %0d over %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BAD],
                 status_seen[ST_UNSUP], status_seen[ST_NULL], status_seen[ST_OVER]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
